### rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the frame header decoder.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPLY(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/mafhd_pkg.sv
// Types, codes, lookup tables and helper functions of the frame header decoder.
// Depends on nothing; every module of the block uses it.
package mafhd_pkg;

  localparam logic [10:0] SYNC_PATTERN = 11'h7ff;

  localparam logic [1:0] VER_25   = 2'd0;
  localparam logic [1:0] VER_RSVD = 2'd1;
  localparam logic [1:0] VER_2    = 2'd2;
  localparam logic [1:0] VER_1    = 2'd3;

  localparam logic [1:0] LAY_RSVD = 2'd0;
  localparam logic [1:0] LAY_3    = 2'd1;
  localparam logic [1:0] LAY_2    = 2'd2;
  localparam logic [1:0] LAY_1    = 2'd3;

  // floor(160 * p / 147) == (p * RECIP_147) >> RECIP_SHIFT for every p below 2048.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [20:0] RECIP_147 = 21'(((160 << RECIP_SHIFT) + 146) / 147);

  // Rows: MPEG1 L1, MPEG1 L2, MPEG1 L3, MPEG2/2.5 L1, MPEG2/2.5 L2 and L3.
  localparam logic [8:0] BR_TAB [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // MPEG1 sample rates; the other versions divide them by two or four.
  localparam logic [15:0] FS_BASE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

  typedef enum logic [1:0] {
    RC_48K,
    RC_32K,
    RC_44K
  } rate_cls_t;

  typedef struct packed {
    logic [1:0] ver;
    logic [1:0] lay;
    logic [1:0] chmode;
    logic [1:0] emph;
    logic       crc;
    logic       pad;
    logic       copy;
    logic       orig;
  } hdr_t;

  // Decode stage output.
  typedef struct packed {
    logic       v;
    logic       ok;
    hdr_t       h;
    logic [8:0] br;
    logic [15:0] fs;
    logic [3:0] k;
    rate_cls_t  cls;
    logic [2:0] pad_add;
  } dec_t;

  // Scaled bitrate stage.
  typedef struct packed {
    logic        v;
    logic        ok;
    hdr_t        h;
    logic [8:0]  br;
    logic [15:0] fs;
    rate_cls_t   cls;
    logic [2:0]  pad_add;
    logic [10:0] p;
  } mul_t;

  // Reciprocal product stage.
  typedef struct packed {
    logic        v;
    logic        ok;
    hdr_t        h;
    logic [8:0]  br;
    logic [15:0] fs;
    rate_cls_t   cls;
    logic [2:0]  pad_add;
    logic [10:0] p;
    logic [31:0] prod;
  } prd_t;

  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] lay,
                                                input logic [3:0] idx);
    logic [8:0] r;
    r = '0;
    if (lay != LAY_RSVD && ver != VER_RSVD) begin
      if (ver == VER_1) begin
        case (lay)
          LAY_1:   r = BR_TAB[0][idx];
          LAY_2:   r = BR_TAB[1][idx];
          default: r = BR_TAB[2][idx];
        endcase
      end else if (lay == LAY_1) begin
        r = BR_TAB[3][idx];
      end else begin
        r = BR_TAB[4][idx];
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] fs_shift(input logic [1:0] ver);
    logic [1:0] s;
    case (ver)
      VER_1:   s = 2'd0;
      VER_2:   s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] fs_lookup(input logic [1:0] ver, input logic [1:0] idx);
    logic [15:0] r;
    r = '0;
    if (ver != VER_RSVD) begin
      r = FS_BASE[idx] >> fs_shift(ver);
    end
    return r;
  endfunction

  function automatic rate_cls_t rate_class(input logic [1:0] idx);
    rate_cls_t c;
    case (idx)
      2'd0:    c = RC_44K;
      2'd1:    c = RC_48K;
      default: c = RC_32K;
    endcase
    return c;
  endfunction

  // Frame length = samples*125*br/fs = k*br scaled by 48000/base, where base is
  // the MPEG1 rate of the same index.
  function automatic logic [3:0] scale_k(input logic [1:0] ver, input logic [1:0] lay);
    logic [3:0] k;
    case (lay)
      LAY_1:   k = 4'd1 << fs_shift(ver);
      LAY_2:   k = 4'd3 << fs_shift(ver);
      LAY_3:   k = (ver == VER_25) ? 4'd6 : 4'd3;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/mpeg_audio_frame_header_decoder.sv
// Top level of the MPEG audio frame header decoder: decode and length stages
// plus the output register. Depends on mafhd_pkg, mafhd_decode, mafhd_len, assert_macros.svh.
//
//  Channel   Handshake            Payload
//  input     start (busy low)     header_word
//  result    done (one cycle)     valid_res ... frame_bytes
//
// A header word is taken in every cycle; busy never rises.
// Each result reaches the ports in order, through four register stages: decode,
// bitrate scaling, reciprocal multiply, and the length select that feeds the
// output register.
// Reset clears only the stage valid bits; results in flight are dropped.
`include "assert_macros.svh"
module mpeg_audio_frame_header_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] header_word,
  output logic        done,
  output logic        valid_res,
  output logic [1:0]  version_code,
  output logic [1:0]  layer_code,
  output logic [1:0]  channel_mode,
  output logic [1:0]  emphasis,
  output logic        crc_flag,
  output logic        padding_flag,
  output logic        copyright_flag,
  output logic        original_flag,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic [11:0] frame_bytes
);

  localparam int unsigned PIPE_LAT = 4;

  mafhd_pkg::dec_t dec_q;
  mafhd_pkg::prd_t prd_q;
  logic [12:0]     p_x3;
  logic [11:0]     quo;
  logic [11:0]     len;

  assign busy = 1'b0;

  mafhd_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .in_v  (start & ~busy),
    .word  (header_word),
    .dec_q (dec_q)
  );

  mafhd_len u_len (
    .clk   (clk),
    .rst   (rst),
    .dec_q (dec_q),
    .prd_q (prd_q)
  );

  always_comb begin
    p_x3 = {2'b00, prd_q.p} + {1'b0, prd_q.p, 1'b0};
    case (prd_q.cls)
      mafhd_pkg::RC_48K: quo = {1'b0, prd_q.p};
      mafhd_pkg::RC_32K: quo = p_x3[12:1];
      mafhd_pkg::RC_44K: quo = prd_q.prod[mafhd_pkg::RECIP_SHIFT +: 12];
      default:           quo = '0;
    endcase
    len = quo + {9'd0, prd_q.pad_add};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prd_q.v;
    end
  end

  // An invalid header shows every field as zero.
  always_ff @(posedge clk) begin
    if (prd_q.ok) begin
      valid_res      <= 1'b1;
      version_code   <= prd_q.h.ver;
      layer_code     <= prd_q.h.lay;
      channel_mode   <= prd_q.h.chmode;
      emphasis       <= prd_q.h.emph;
      crc_flag       <= prd_q.h.crc;
      padding_flag   <= prd_q.h.pad;
      copyright_flag <= prd_q.h.copy;
      original_flag  <= prd_q.h.orig;
      bitrate_kbps   <= prd_q.br;
      sample_rate_hz <= prd_q.fs;
      frame_bytes    <= len;
    end else begin
      valid_res      <= 1'b0;
      version_code   <= '0;
      layer_code     <= '0;
      channel_mode   <= '0;
      emphasis       <= '0;
      crc_flag       <= 1'b0;
      padding_flag   <= 1'b0;
      copyright_flag <= 1'b0;
      original_flag  <= 1'b0;
      bitrate_kbps   <= '0;
      sample_rate_hz <= '0;
      frame_bytes    <= '0;
    end
  end

  `CHK_IMPLY(a_latency, clk, rst, done, $past(start, PIPE_LAT))
  `CHK_NEXT(a_stage_to_out, clk, rst, prd_q.v && prd_q.ok, done && valid_res)
  `CHK_IMPLY(a_valid_nonzero, clk, rst, done && valid_res, (frame_bytes != '0) && (bitrate_kbps != '0) && (sample_rate_hz != '0))
  `CHK_IMPLY(a_invalid_zero, clk, rst, done && !valid_res, (frame_bytes == '0) && (bitrate_kbps == '0) && (sample_rate_hz == '0))

endmodule

### rtl/core/mafhd_decode.sv
// Decode stage: splits the header word, checks sync and looks up the rates.
// Depends on mafhd_pkg.
module mafhd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  logic [31:0]       word,
  output mafhd_pkg::dec_t   dec_q
);

  mafhd_pkg::hdr_t h;
  logic [8:0]      br;
  logic [15:0]     fs;
  logic            ok;

  always_comb begin
    h.ver    = word[20:19];
    h.lay    = word[18:17];
    h.crc    = word[16];
    h.pad    = word[9];
    h.chmode = word[7:6];
    h.copy   = word[3];
    h.orig   = word[2];
    h.emph   = word[1:0];
    br = mafhd_pkg::bitrate_lookup(h.ver, h.lay, word[15:12]);
    fs = mafhd_pkg::fs_lookup(h.ver, word[11:10]);
    ok = (word[31:21] == mafhd_pkg::SYNC_PATTERN) && (br != '0) && (fs != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_q.v <= 1'b0;
    end else begin
      dec_q.v <= in_v;
    end
    dec_q.ok      <= ok;
    dec_q.h       <= h;
    dec_q.br      <= br;
    dec_q.fs      <= fs;
    dec_q.k       <= mafhd_pkg::scale_k(h.ver, h.lay);
    dec_q.cls     <= mafhd_pkg::rate_class(word[11:10]);
    // A Layer I slot is four bytes, the other layers use one byte.
    dec_q.pad_add <= h.pad ? ((h.lay == mafhd_pkg::LAY_1) ? 3'd4 : 3'd1) : 3'd0;
  end

endmodule

### rtl/core/mafhd_len.sv
// Length arithmetic stages: scales the bitrate, then multiplies by the
// reciprocal used for the 44.1 kHz family. Depends on mafhd_pkg.
module mafhd_len (
  input  logic            clk,
  input  logic            rst,
  input  mafhd_pkg::dec_t dec_q,
  output mafhd_pkg::prd_t prd_q
);

  mafhd_pkg::mul_t mul_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_q.v <= 1'b0;
      prd_q.v <= 1'b0;
    end else begin
      mul_q.v <= dec_q.v;
      prd_q.v <= mul_q.v;
    end

    mul_q.ok      <= dec_q.ok;
    mul_q.h       <= dec_q.h;
    mul_q.br      <= dec_q.br;
    mul_q.fs      <= dec_q.fs;
    mul_q.cls     <= dec_q.cls;
    mul_q.pad_add <= dec_q.pad_add;
    mul_q.p       <= {2'b00, dec_q.br} * {7'b0000000, dec_q.k};

    prd_q.ok      <= mul_q.ok;
    prd_q.h       <= mul_q.h;
    prd_q.br      <= mul_q.br;
    prd_q.fs      <= mul_q.fs;
    prd_q.cls     <= mul_q.cls;
    prd_q.pad_add <= mul_q.pad_add;
    prd_q.p       <= mul_q.p;
    prd_q.prod    <= {21'd0, mul_q.p} * {11'd0, mafhd_pkg::RECIP_147};
  end

endmodule

### tb/tb_mpeg_audio_frame_header_decoder.sv
// Self-checking testbench for mpeg_audio_frame_header_decoder.
// Depends on mafhd_pkg for the sync pattern and the version and layer codes; predicts every result
// from the header word and compares it field by field with the block's output.
`timescale 1ns / 1ps

module tb_mpeg_audio_frame_header_decoder;

  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned TAIL_CYCLES   = 8;

  typedef struct packed {
    logic        valid;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic [1:0]  chmode;
    logic [1:0]  emph;
    logic        crc;
    logic        pad;
    logic        copyr;
    logic        orig;
    logic [8:0]  kbps;
    logic [15:0] rate_hz;
    logic [11:0] length;
  } frame_info_t;

  typedef struct packed {
    logic        drain_mark;
    logic        gaps_allowed;
    logic [31:0] word;
  } header_item_t;

  // Rows: MPEG1 L1, MPEG1 L2, MPEG1 L3, MPEG2/2.5 L1, MPEG2/2.5 L2 and L3.
  int unsigned kbps_tab [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };
  // Rows: MPEG1, MPEG2, MPEG2.5.
  int unsigned rate_tab [3][4] = '{
    '{44100, 48000, 32000, 0},
    '{22050, 24000, 16000, 0},
    '{11025, 12000, 8000, 0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] header_word = '0;
  logic        busy;
  logic        done;
  logic        valid_res;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic [1:0]  channel_mode;
  logic [1:0]  emphasis;
  logic        crc_flag;
  logic        padding_flag;
  logic        copyright_flag;
  logic        original_flag;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [11:0] frame_bytes;

  header_item_t header_queue [$];
  frame_info_t  expected_frames [$];
  int unsigned  in_flight_seen = 0;
  int unsigned  gap_left = 0;
  bit           gap_taken = 1'b0;
  int unsigned  error_count = 0;
  int unsigned  headers_taken = 0;
  int unsigned  valid_seen = 0;
  int unsigned  invalid_seen = 0;
  int unsigned  quiet_cycles = 0;

  mpeg_audio_frame_header_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .header_word    (header_word),
    .done           (done),
    .valid_res      (valid_res),
    .version_code   (version_code),
    .layer_code     (layer_code),
    .channel_mode   (channel_mode),
    .emphasis       (emphasis),
    .crc_flag       (crc_flag),
    .padding_flag   (padding_flag),
    .copyright_flag (copyright_flag),
    .original_flag  (original_flag),
    .bitrate_kbps   (bitrate_kbps),
    .sample_rate_hz (sample_rate_hz),
    .frame_bytes    (frame_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic frame_info_t decode_frame_header(input logic [31:0] w);
    frame_info_t f;
    logic [1:0]  ver;
    logic [1:0]  lay;
    int unsigned kbps;
    int unsigned hz;
    int unsigned samples;
    int unsigned len;
    f = '0;
    ver = w[20:19];
    lay = w[18:17];
    kbps = 0;
    hz = 0;
    if (w[31:21] != mafhd_pkg::SYNC_PATTERN) return f;
    if (lay != mafhd_pkg::LAY_RSVD && ver != mafhd_pkg::VER_RSVD) begin
      if (ver == mafhd_pkg::VER_1) begin
        case (lay)
          mafhd_pkg::LAY_1: kbps = kbps_tab[0][w[15:12]];
          mafhd_pkg::LAY_2: kbps = kbps_tab[1][w[15:12]];
          default:          kbps = kbps_tab[2][w[15:12]];
        endcase
      end else begin
        kbps = (lay == mafhd_pkg::LAY_1) ? kbps_tab[3][w[15:12]] : kbps_tab[4][w[15:12]];
      end
    end
    case (ver)
      mafhd_pkg::VER_1:  hz = rate_tab[0][w[11:10]];
      mafhd_pkg::VER_2:  hz = rate_tab[1][w[11:10]];
      mafhd_pkg::VER_25: hz = rate_tab[2][w[11:10]];
      default:           hz = 0;
    endcase
    if (kbps == 0 || hz == 0) return f;
    case (lay)
      mafhd_pkg::LAY_1: samples = 384;
      mafhd_pkg::LAY_2: samples = 1152;
      default:          samples = (ver == mafhd_pkg::VER_1) ? 1152 : 576;
    endcase
    len = samples * kbps * 125 / hz;
    if (w[9]) len += (lay == mafhd_pkg::LAY_1) ? 4 : 1;
    f.valid   = 1'b1;
    f.version = ver;
    f.layer   = lay;
    f.chmode  = w[7:6];
    f.emph    = w[1:0];
    f.crc     = w[16];
    f.pad     = w[9];
    f.copyr   = w[3];
    f.orig    = w[2];
    f.kbps    = kbps[8:0];
    f.rate_hz = hz[15:0];
    f.length  = len[11:0];
    return f;
  endfunction

  // The misc bits fill the protection bit (top) and bits 8..0 of the header.
  function automatic logic [31:0] build_header(input logic [1:0] ver, input logic [1:0] lay,
                                               input logic [3:0] br_idx,
                                               input logic [1:0] fs_idx, input logic pad,
                                               input logic [9:0] misc);
    return {mafhd_pkg::SYNC_PATTERN, ver, lay, misc[9], br_idx, fs_idx, pad, misc[8:0]};
  endfunction

  function automatic logic [31:0] random_header();
    int unsigned pick;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  br_idx;
    logic [1:0]  fs_idx;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       ver = mafhd_pkg::VER_1;
      1:       ver = mafhd_pkg::VER_2;
      default: ver = mafhd_pkg::VER_25;
    endcase
    lay = 2'($urandom_range(1, 3));
    br_idx = 4'($urandom_range(1, 14));
    fs_idx = 2'($urandom_range(0, 2));
    if (pick >= 80 && pick < 90) begin
      // Well-formed apart from one field that makes the header invalid.
      case ($urandom_range(0, 4))
        0:       br_idx = 4'd0;
        1:       br_idx = 4'd15;
        2:       fs_idx = 2'd3;
        3:       ver = mafhd_pkg::VER_RSVD;
        default: lay = mafhd_pkg::LAY_RSVD;
      endcase
    end
    w = build_header(ver, lay, br_idx, fs_idx, 1'($urandom()), 10'($urandom()));
    if (pick >= 90 && pick < 95) w ^= 32'd1 << $urandom_range(21, 31);
    else if (pick >= 95) w = $urandom();
    return w;
  endfunction

  task automatic add_header(input logic [31:0] w, input logic gaps);
    header_queue.push_back('{drain_mark: 1'b0, gaps_allowed: gaps, word: w});
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Driver: presents one header per beat, with random idle bursts between beats where the item allows them.
  always @(posedge clk) begin
    logic         next_start;
    logic [31:0]  next_word;
    header_item_t item;
    next_start = start;
    next_word = header_word;
    if (rst) begin
      next_start = 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      next_start = 1'b0;
      next_word = $urandom();
      if (gap_left > 0) begin
        gap_left--;
      end else if (header_queue.size() > 0) begin
        if (header_queue[0].drain_mark) begin
          // Hold off until the pipeline has delivered everything it owes.
          if (!start && in_flight_seen == 0) void'(header_queue.pop_front());
        end else if (header_queue[0].gaps_allowed && !gap_taken &&
                     $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 7);
          gap_taken = 1'b1;
        end else begin
          item = header_queue.pop_front();
          next_word = item.word;
          next_start = 1'b1;
          gap_taken = 1'b0;
        end
      end
    end
    start <= next_start;
    header_word <= next_word;
  end

  // Monitor: records the expectation of every accepted beat and checks results.
  always @(posedge clk) begin
    frame_info_t want;
    if (!rst) begin
      if (start && !busy) begin
        expected_frames.push_back(decode_frame_header(header_word));
        headers_taken++;
      end
      if (done) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result with no header pending, expected none, actual frame_bytes %0d",
                   $realtime, frame_bytes);
          error_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("valid_res", 32'(want.valid), 32'(valid_res));
          check_field("version_code", 32'(want.version), 32'(version_code));
          check_field("layer_code", 32'(want.layer), 32'(layer_code));
          check_field("channel_mode", 32'(want.chmode), 32'(channel_mode));
          check_field("emphasis", 32'(want.emph), 32'(emphasis));
          check_field("crc_flag", 32'(want.crc), 32'(crc_flag));
          check_field("padding_flag", 32'(want.pad), 32'(padding_flag));
          check_field("copyright_flag", 32'(want.copyr), 32'(copyright_flag));
          check_field("original_flag", 32'(want.orig), 32'(original_flag));
          check_field("bitrate_kbps", 32'(want.kbps), 32'(bitrate_kbps));
          check_field("sample_rate_hz", 32'(want.rate_hz), 32'(sample_rate_hz));
          check_field("frame_bytes", 32'(want.length), 32'(frame_bytes));
          if (want.valid) valid_seen++;
          else invalid_seen++;
        end
      end
    end
  end

  always @(negedge clk) in_flight_seen <= expected_frames.size();

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed headers: table corners, every version and layer, invalid cases.
    add_header(32'h0000_0000, 1'b1);
    add_header(32'hFFFF_FFFF, 1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_1, 4'd14, 2'd2, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_25, mafhd_pkg::LAY_2, 4'd14, 2'd2, 1'b1, 10'h000),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_2, 4'd14, 2'd2, 1'b0, 10'h155),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_3, 4'd1, 2'd1, 1'b0, 10'h2AA),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_3, 4'd9, 2'd0, 1'b1, 10'h0C0),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_1, 4'd1, 2'd0, 1'b1, 10'h040),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_2, mafhd_pkg::LAY_1, 4'd14, 2'd0, 1'b1, 10'h080),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_2, mafhd_pkg::LAY_2, 4'd7, 2'd1, 1'b0, 10'h00C),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_2, mafhd_pkg::LAY_3, 4'd1, 2'd2, 1'b1, 10'h003),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_25, mafhd_pkg::LAY_1, 4'd5, 2'd0, 1'b0, 10'h200),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_25, mafhd_pkg::LAY_3, 4'd14, 2'd2, 1'b1, 10'h1FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_25, mafhd_pkg::LAY_2, 4'd1, 2'd1, 1'b0, 10'h001),
               1'b1);
    // Sync off by one bit, otherwise a good header.
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_3, 4'd9, 2'd0, 1'b0, 10'h000)
               ^ 32'h0020_0000, 1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_3, 4'd9, 2'd0, 1'b0, 10'h000)
               ^ 32'h8000_0000, 1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_3, 4'd0, 2'd0, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_2, mafhd_pkg::LAY_2, 4'd15, 2'd1, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_RSVD, 4'd9, 2'd0, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_RSVD, mafhd_pkg::LAY_3, 4'd9, 2'd0, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_1, mafhd_pkg::LAY_2, 4'd9, 2'd3, 1'b1, 10'h3FF),
               1'b1);
    add_header(build_header(mafhd_pkg::VER_2, mafhd_pkg::LAY_3, 4'd8, 2'd3, 1'b0, 10'h000),
               1'b1);

    for (int i = 0; i < 300; i++) add_header(random_header(), 1'b1);
    for (int i = 0; i < 100; i++) add_header(random_header(), 1'b0);
    header_queue.push_back('{drain_mark: 1'b1, gaps_allowed: 1'b0, word: 32'h0});
    for (int i = 0; i < 150; i++) add_header(random_header(), 1'b1);
    for (int i = 0; i < 100; i++) add_header(random_header(), 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (header_queue.size() != 0 || start || expected_frames.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_frames.size() != 0) begin
      $display("%0t: results still pending at end, expected 0, actual %0d",
               $realtime, expected_frames.size());
      error_count++;
    end

    $display("Checked %0d header beats: %0d decoded frames and %0d rejected headers,",
             headers_taken, valid_seen, invalid_seen);
    $display("covering all versions, layers, table edges and idle bursts on the input.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
